// ===== hw/rtl/adsd_pkg.sv =====
// Shared types, codes and tables for the ADPCM sound device.
// Used by every module under hw/rtl; depends on nothing.
package adsd_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int RATE_W     = 18;
  localparam int PHASE_W    = 32;
  localparam int SIG_W      = 12;
  localparam int POS_W      = 6;
  localparam int STEP_W     = 11;
  localparam int SAMPLE_W   = 15;

  localparam logic [RATE_W-1:0]  DEFAULT_RATE = RATE_W'(15625);
  localparam logic [POS_W-1:0]   STEP_POS_MAX = POS_W'(48);
  localparam logic signed [SIG_W-1:0] SIG_MIN = -SIG_W'(2048);
  localparam logic signed [SIG_W-1:0] SIG_MAX = SIG_W'(2047);

  // Input kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Command bits
  localparam int CMD_STOP_BIT = 0;
  localparam int CMD_PLAY_BIT = 1;

  // Register indexes
  localparam logic REG_OUTPUT_RATE = 1'b0;
  localparam logic REG_SOURCE_RATE = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       busy_res;
  } result_t;

  // Work handed from the control stage to the decode stage
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_STATUS,
    OP_ZERO,
    OP_HOLD,
    OP_UNDER,
    OP_DEC_HIGH,
    OP_DEC_LOW
  } op_code_t;

  typedef struct packed {
    op_code_t op;
    logic     busy;
  } stage_op_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_ctl_t;

  function automatic logic [STEP_W-1:0] step_size(input logic [POS_W-1:0] pos);
    logic [STEP_W-1:0] s;
    case (pos)
      6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
      6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
      6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
      6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
      6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
      6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
      6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
      6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
      6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
      6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
      6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
      6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
      6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      default: s = 11'd1552;
    endcase
    return s;
  endfunction

  // Index move: -1 for small magnitudes, 2/4/6/8 for large ones
  function automatic logic signed [4:0] step_move(input logic [2:0] mag);
    logic signed [4:0] m;
    if (mag[2]) begin
      m = $signed({2'b00, mag[1:0], 1'b0}) + 5'sd2;
    end else begin
      m = -5'sd1;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/adsd_top.sv =====
// Top level of the ADPCM sound device: control stage, FIFO RAM and decode stage.
// Depends on adsd_pkg, adsd_fifo_ram, adsd_ctrl and adsd_decode.
//
// The device takes one transaction per clock cycle without a bubble while
// result_stall is low, whatever the mix of commands, data bytes, status reads
// and ticks; only status reads and ticks give a result. The accepting cycle
// runs the FIFO pointers, play state and phase accumulator and starts the read
// of the next byte from the FIFO memory, whose registered data feeds the decode
// stage. The decode stage then runs the nibble decoder and loads the output
// register. Input stall rises only when the output register is full and held
// by result_stall. The FIFO memory needs no clearing after reset, so the device
// is ready from the first cycle. Rate registers take effect at once and must be
// written while no transaction is in flight.
module adpcm_sound_device_top import adsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [RATE_W-1:0] cfg_data
);

  logic       accept;
  stage_op_t  op;
  ram_ctl_t   ram;
  logic [7:0] rdata;

  assign accept = item_valid && !item_stall;

  adsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .ram       (ram)
  );

  adsd_fifo_ram u_ram (
    .clk   (clk),
    .ctl   (ram),
    .rdata (rdata)
  );

  adsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op_in        (op),
    .rdata        (rdata),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== hw/rtl/adsd_fifo_ram.sv =====
// Byte FIFO storage: one write port, one read port with registered data.
// Depends on adsd_pkg for depth and the port control struct.
module adsd_fifo_ram import adsd_pkg::*; (
  input  logic     clk,
  input  ram_ctl_t ctl,
  output logic [7:0] rdata
);

  logic [7:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

// ===== hw/rtl/adsd_ctrl.sv =====
// Control stage: rate registers, play state, FIFO pointers, phase and nibble phase.
// Depends on adsd_pkg; drives the FIFO RAM and hands an op to adsd_decode.
module adsd_ctrl import adsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  item_t             item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [RATE_W-1:0] cfg_data,
  output stage_op_t         op,
  output ram_ctl_t          ram
);

  logic [RATE_W-1:0]  output_rate;
  logic [RATE_W-1:0]  source_rate;
  logic               playing, playing_next;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic               low_pending, low_pending_next;
  logic [PHASE_W-1:0] phase, phase_next;

  logic [PHASE_W-1:0] phase_sum;
  logic [PTR_W+1:0]   wsum;
  logic [RATE_W-1:0]  cfg_val;

  assign phase_sum = phase + PHASE_W'(source_rate);
  assign wsum      = (PTR_W+2)'(read_pointer) + (PTR_W+2)'(fill_count);
  assign cfg_val   = (cfg_data == '0) ? DEFAULT_RATE : cfg_data;

  always_comb begin
    playing_next      = playing;
    read_pointer_next = read_pointer;
    fill_count_next   = fill_count;
    low_pending_next  = low_pending;
    phase_next        = phase;
    op.op             = OP_NONE;
    op.busy           = 1'b0;
    ram.we            = 1'b0;
    ram.wdata         = item.value;
    ram.re            = 1'b0;
    ram.raddr         = read_pointer;
    if (wsum >= (PTR_W+2)'(FIFO_DEPTH)) begin
      ram.waddr = PTR_W'(wsum - (PTR_W+2)'(FIFO_DEPTH));
    end else begin
      ram.waddr = PTR_W'(wsum);
    end

    if (accept) begin
      case (item.kind)
        KIND_CMD: begin
          if (item.value[CMD_STOP_BIT]) begin
            playing_next      = 1'b0;
            read_pointer_next = '0;
            fill_count_next   = '0;
            low_pending_next  = 1'b0;
            phase_next        = '0;
            op.op             = OP_CLEAR;
          end else if (item.value[CMD_PLAY_BIT]) begin
            playing_next = 1'b1;
          end
        end
        KIND_DATA: begin
          // Drop the byte when full
          if (fill_count < CNT_W'(FIFO_DEPTH)) begin
            ram.we          = 1'b1;
            fill_count_next = fill_count + 1'b1;
          end
        end
        KIND_STATUS: begin
          op.op   = OP_STATUS;
          op.busy = playing && (fill_count != '0);
        end
        default: begin
          if (!playing) begin
            op.op = OP_ZERO;
          end else if (phase_sum < PHASE_W'(output_rate)) begin
            phase_next = phase_sum;
            op.op      = OP_HOLD;
          end else begin
            phase_next = phase_sum - PHASE_W'(output_rate);
            if (low_pending) begin
              low_pending_next = 1'b0;
              op.op            = OP_DEC_LOW;
            end else if (fill_count == '0) begin
              op.op = OP_UNDER;
            end else begin
              ram.re           = 1'b1;
              low_pending_next = 1'b1;
              fill_count_next  = fill_count - 1'b1;
              if (read_pointer == PTR_W'(FIFO_DEPTH - 1)) begin
                read_pointer_next = '0;
              end else begin
                read_pointer_next = read_pointer + 1'b1;
              end
              op.op = OP_DEC_HIGH;
            end
          end
        end
      endcase
    end

    // The user must write rates only while idle; the block does not enforce it. Rate writes restart the phase
    if (cfg_we) begin
      phase_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_rate  <= DEFAULT_RATE;
      source_rate  <= DEFAULT_RATE;
      playing      <= 1'b0;
      read_pointer <= '0;
      fill_count   <= '0;
      low_pending  <= 1'b0;
      phase        <= '0;
    end else begin
      playing      <= playing_next;
      read_pointer <= read_pointer_next;
      fill_count   <= fill_count_next;
      low_pending  <= low_pending_next;
      phase        <= phase_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_OUTPUT_RATE: output_rate <= cfg_val;
          REG_SOURCE_RATE: source_rate <= cfg_val;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(FIFO_DEPTH))
    else $error("fill count above FIFO depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    read_pointer < PTR_W'(FIFO_DEPTH - 1) || read_pointer == PTR_W'(FIFO_DEPTH - 1))
    else $error("read pointer out of range");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    ram.re |-> (fill_count != '0 && !low_pending && playing))
    else $error("FIFO read while empty or nibble pending");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (op.op == OP_CLEAR && !cfg_we) |=> (fill_count == '0 && !playing && !low_pending))
    else $error("stop left run state behind");
`endif

endmodule

// ===== hw/rtl/adsd_decode.sv =====
// Decode stage: ADPCM decoder state, held sample and the output register.
// Depends on adsd_pkg; takes ops from adsd_ctrl and bytes from adsd_fifo_ram.
module adsd_decode import adsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  stage_op_t  op_in,
  input  logic [7:0] rdata,
  output logic       item_stall,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  logic                       s2_valid;
  stage_op_t                  s2;
  logic                       out_ready;
  logic                       take;

  logic [7:0]                 held_byte;
  logic signed [SIG_W-1:0]    signal_level, signal_next;
  logic [POS_W-1:0]           step_pos, step_pos_next;
  logic signed [SAMPLE_W-1:0] held_sample;

  logic [3:0]                 nib;
  logic [STEP_W-1:0]          step;
  logic [SIG_W-1:0]           diff;
  logic signed [SIG_W+1:0]    sig_sum;
  logic signed [7:0]          pos_sum;
  logic                       is_dec;

  assign out_ready  = !result_valid || !result_stall;
  assign take       = s2_valid && out_ready;
  assign item_stall = s2_valid && !out_ready;
  assign is_dec     = (s2.op == OP_DEC_HIGH) || (s2.op == OP_DEC_LOW);

  always_comb begin
    nib  = (s2.op == OP_DEC_HIGH) ? rdata[7:4] : held_byte[3:0];
    step = step_size(step_pos);
    diff = SIG_W'(step >> 3);
    if (nib[2]) diff = diff + SIG_W'(step);
    if (nib[1]) diff = diff + SIG_W'(step >> 1);
    if (nib[0]) diff = diff + SIG_W'(step >> 2);
    if (nib[3]) begin
      sig_sum = (SIG_W+2)'(signal_level) - $signed({2'b00, diff});
    end else begin
      sig_sum = (SIG_W+2)'(signal_level) + $signed({2'b00, diff});
    end
    if (sig_sum < (SIG_W+2)'(SIG_MIN)) begin
      signal_next = SIG_MIN;
    end else if (sig_sum > (SIG_W+2)'(SIG_MAX)) begin
      signal_next = SIG_MAX;
    end else begin
      signal_next = SIG_W'(sig_sum);
    end
    pos_sum = $signed({2'b00, step_pos}) + 8'(step_move(nib[2:0]));
    if (pos_sum < 0) begin
      step_pos_next = '0;
    end else if (pos_sum > $signed({2'b00, STEP_POS_MAX})) begin
      step_pos_next = STEP_POS_MAX;
    end else begin
      step_pos_next = POS_W'(pos_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      held_byte    <= '0;
      signal_level <= '0;
      step_pos     <= '0;
      held_sample  <= '0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (take) begin
        s2_valid <= 1'b0;
      end
      if (out_ready) begin
        result_valid <= take && (s2.op != OP_NONE) && (s2.op != OP_CLEAR);
      end
      if (take) begin
        result.busy_res <= s2.busy;
        result.sample   <= '0;
        case (s2.op)
          OP_CLEAR: begin
            signal_level <= '0;
            step_pos     <= '0;
            held_sample  <= '0;
          end
          OP_HOLD: begin
            result.sample <= held_sample;
          end
          OP_UNDER: begin
            held_sample <= '0;
          end
          OP_DEC_HIGH, OP_DEC_LOW: begin
            signal_level  <= signal_next;
            step_pos      <= step_pos_next;
            held_sample   <= {signal_next, 3'b000};
            result.sample <= {signal_next, 3'b000};
            if (s2.op == OP_DEC_HIGH) begin
              held_byte <= rdata;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2 <= op_in;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    step_pos <= STEP_POS_MAX)
    else $error("step index above table range");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (take && s2.op == OP_CLEAR) |=> (held_sample == '0 && signal_level == '0))
    else $error("clear left decoder state behind");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.busy_res) |-> (result.sample == '0))
    else $error("status result carries a sample");

  a_dec_tracks: assert property (@(posedge clk) disable iff (rst)
    (take && is_dec) |=> (held_sample == {signal_level, 3'b000}))
    else $error("held sample out of step with signal level");
`endif

endmodule
